// ===== sv/tce_pkg.sv =====
package tce_pkg;

	// Screen geometry
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STEP = 4;
	localparam int CELLS    = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LIN_W  = ADDR_W + 1;
	localparam int TAB_PW = (TAB_STEP > 1) ? $clog2(TAB_STEP) : 1;

	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [TAB_PW-1:0] TAB_LAST  = TAB_PW'(TAB_STEP - 1);
	localparam logic [TAB_PW-1:0] COL_LAST_PHASE = TAB_PW'((COLUMNS - 1) % TAB_STEP);

	// Field widths on the stream ports
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int ENTRY_W     = 16;
	localparam int CROW_W      = 5;
	localparam int CCOL_W      = 7;
	localparam int CPOS_W      = 11;
	localparam int ATTR_W      = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (ENTRY_W + CROW_W + CCOL_W + CPOS_W);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [ATTR_W-1:0] LIGHT_GREY   = 8'd7;
	localparam logic [ENTRY_W-1:0] RESET_CELL  = {LIGHT_GREY, CH_SPACE};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_READ,
		OP_PUT,
		OP_NEWLINE,
		OP_TAB,
		OP_BACKSPACE,
		OP_RETURN
	} tce_op_t;

	typedef struct packed {
		tce_op_t             op;
		logic [CHAR_W-1:0]   chr;
		logic [INDEX_W-1:0]  idx;
		logic                idx_ok;
	} tce_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_BS_WR,
		ST_TAB,
		ST_BLANK,
		ST_FINISH
	} tce_state_t;

	// Fold a sum below twice the screen size back into the store
	function automatic logic [ADDR_W-1:0] wrap_addr(input logic [LIN_W-1:0] sum);
		logic [LIN_W-1:0] adj;
		adj = (sum >= LIN_W'(CELLS)) ? (sum - LIN_W'(CELLS)) : sum;
		return adj[ADDR_W-1:0];
	endfunction

	// Linear cursor position, row * COLUMNS + column
	function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [LIN_W-1:0] lin;
		lin = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
		return lin[ADDR_W-1:0];
	endfunction

	// Physical store address of a logical cell, given the scroll offset
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [ADDR_W-1:0] base);
		return wrap_addr(LIN_W'(lin_pos(row, col)) + LIN_W'(base));
	endfunction

endpackage

// ===== sv/text_console_character_engine.sv =====
// Text console engine with a 25 x 80 screen of 16-bit cells (character in the
// low byte, attribute in the high byte) and a cursor. Send a put transaction
// (tuser = 0) with a character byte: newline, return, tab and backspace move
// the cursor, any other byte is written in the current text color and the
// cursor advances; passing the bottom row scrolls the screen up. Send a read
// transaction (tuser = 1) with a linear cell index to get that cell back;
// indexes past the screen return 0. Every transaction yields one result that
// carries the cursor after the item. After reset the engine runs a clearing
// pass, one cell per cycle, and holds s_axis_tready low until it ends. The
// back end drives a single-write-port screen memory and handles one item at
// a time; a tab writes one to four blanks, and a scroll blanks the new bottom
// row. Scrolling moves a top-row offset, so no cells are copied. A two-entry
// queue between the classifying front end and the back end keeps input
// flowing while a result waits on m_axis.
// Write text_color only while the engine is idle.
module text_console_character_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tce_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // char_code[7:0], cell_index[18:8], zero pad
	input  logic                             s_axis_tuser,  // func
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tce_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // cell_entry[15:0], cursor_row[20:16],
	                                                        // cursor_column[27:21], cursor_position[38:28]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tce_pkg::ATTR_W-1:0]       cfg_data       // text_color
);
	import tce_pkg::*;

	logic [ATTR_W-1:0] text_color_q;
	logic              clearing;
	logic              q_full;
	logic              q_push;
	tce_cmd_t          q_push_cmd;
	logic              q_pop;
	logic              q_valid;
	tce_cmd_t          q_pop_cmd;

	// Always take configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= LIGHT_GREY;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// Front end: accept and classify
	tce_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.clearing      (clearing),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_push_cmd)
	);

	// Decouple the two halves
	tce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (q_pop_cmd)
	);

	// Back end: cursor, screen memory, scroll and result register
	tce_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_color    (text_color_q),
		.q_valid       (q_valid),
		.q_cmd         (q_pop_cmd),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== sv/tce_front.sv =====
module tce_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tce_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // char_code, cell_index, zero pad
	input  logic                             s_axis_tuser,  // func
	input  logic                             clearing,
	input  logic                             q_full,
	output logic                             q_push,
	output tce_pkg::tce_cmd_t                q_cmd
);
	import tce_pkg::*;

	logic              valid_s1;
	tce_cmd_t          cmd_s1;
	tce_cmd_t          cmd_in;
	logic              accept;
	logic [CHAR_W-1:0] chr_in;
	logic [INDEX_W-1:0] idx_in;

	assign chr_in = s_axis_tdata[CHAR_W-1:0];
	assign idx_in = s_axis_tdata[CHAR_W +: INDEX_W];

	// Classify the byte into an operation
	always_comb begin
		cmd_in.chr    = chr_in;
		cmd_in.idx    = idx_in;
		cmd_in.idx_ok = (idx_in < INDEX_W'(CELLS));
		if (s_axis_tuser) begin
			cmd_in.op = OP_READ;
		end else begin
			case (chr_in)
				CH_NEWLINE:   cmd_in.op = OP_NEWLINE;
				CH_TAB:       cmd_in.op = OP_TAB;
				CH_BACKSPACE: cmd_in.op = OP_BACKSPACE;
				CH_RETURN:    cmd_in.op = OP_RETURN;
				default:      cmd_in.op = OP_PUT;
			endcase
		end
	end

	assign q_push        = valid_s1 && !q_full;
	assign s_axis_tready = !clearing && (!valid_s1 || !q_full);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_cmd         = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !q_push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

// ===== sv/tce_queue.sv =====
module tce_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tce_pkg::tce_cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output tce_pkg::tce_cmd_t  pop_cmd
);
	import tce_pkg::*;

	tce_cmd_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== sv/tce_back.sv =====
module tce_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tce_pkg::ATTR_W-1:0]        text_color,
	input  logic                              q_valid,
	input  tce_pkg::tce_cmd_t                 q_cmd,
	output logic                              q_pop,
	output logic                              clearing,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tce_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import tce_pkg::*;

	tce_state_t          state_q, state_d;
	tce_cmd_t            cmd_q;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [TAB_PW-1:0]   phase_q, phase_d;
	logic [ADDR_W-1:0]   base_q, base_d;
	logic [ADDR_W-1:0]   cnt_q, cnt_d;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [ENTRY_W-1:0]  mem_q [CELLS];
	logic [ENTRY_W-1:0]  rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic                at_row_end;
	logic                at_last_row;
	logic                do_nr;
	logic                out_load;
	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W-1:0]   base_next;
	logic [ENTRY_W-1:0]  entry_val;
	logic [TAB_PW-1:0]   phase_inc;
	logic [TAB_PW-1:0]   phase_dec;

	assign at_row_end  = (col_q == COL_LAST);
	assign at_last_row = (row_q == ROW_LAST);
	assign cur_addr    = cell_addr(row_q, col_q, base_q);
	assign base_next   = wrap_addr(LIN_W'(base_q) + LIN_W'(COLUMNS));
	assign phase_inc   = (phase_q == TAB_LAST) ? '0 : phase_q + TAB_PW'(1);
	assign phase_dec   = (phase_q == '0) ? TAB_LAST : phase_q - TAB_PW'(1);
	assign clearing    = (state_q == ST_CLEAR);
	assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign entry_val   = (cmd_q.op == OP_READ && cmd_q.idx_ok) ? rdata_q : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_q == CELL_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q.op)
					OP_PUT: begin
						state_d = (at_row_end && at_last_row) ? ST_BLANK : ST_FINISH;
					end
					OP_NEWLINE:   state_d = at_last_row ? ST_BLANK : ST_FINISH;
					OP_TAB:       state_d = ST_TAB;
					OP_BACKSPACE: state_d = ST_BS_WR;
					default:      state_d = ST_FINISH;
				endcase
			end
			ST_TAB: begin
				if (at_row_end) begin
					state_d = at_last_row ? ST_BLANK : ST_FINISH;
				end else if (phase_q == TAB_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_BS_WR: state_d = ST_FINISH;
			ST_BLANK: begin
				if (cnt_q[COL_W-1:0] == COL_LAST) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Datapath controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {text_color, CH_SPACE};
		mem_re    = 1'b0;
		mem_raddr = cmd_q.idx_ok ?
			wrap_addr(LIN_W'(ADDR_W'(cmd_q.idx)) + LIN_W'(base_q)) : '0;
		row_d     = row_q;
		col_d     = col_q;
		phase_d   = phase_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		do_nr     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = RESET_CELL;
				cnt_d     = cnt_q + ADDR_W'(1);
			end
			ST_EXEC: begin
				case (cmd_q.op)
					OP_READ: mem_re = 1'b1;
					OP_PUT: begin
						mem_we    = 1'b1;
						mem_wdata = {text_color, cmd_q.chr};
						if (at_row_end) begin
							do_nr = 1'b1;
						end else begin
							col_d   = col_q + COL_W'(1);
							phase_d = phase_inc;
						end
					end
					OP_NEWLINE: do_nr = 1'b1;
					OP_RETURN: begin
						col_d   = '0;
						phase_d = '0;
					end
					OP_BACKSPACE: begin
						if (col_q != '0) begin
							col_d   = col_q - COL_W'(1);
							phase_d = phase_dec;
						end else if (row_q != '0) begin
							row_d   = row_q - ROW_W'(1);
							col_d   = COL_LAST;
							phase_d = COL_LAST_PHASE;
						end
					end
					default: ;
				endcase
			end
			ST_TAB: begin
				mem_we = 1'b1;
				if (at_row_end) begin
					do_nr = 1'b1;
				end else begin
					col_d   = col_q + COL_W'(1);
					phase_d = phase_inc;
				end
			end
			ST_BS_WR: mem_we = 1'b1;
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(ROW_LAST, cnt_q[COL_W-1:0], base_q);
				cnt_d     = cnt_q + ADDR_W'(1);
			end
			default: ;
		endcase
		// Move to the next row; scroll by advancing the top-row offset
		if (do_nr) begin
			col_d   = '0;
			phase_d = '0;
			if (at_last_row) begin
				base_d = base_next;
				cnt_d  = '0;
			end else begin
				row_d = row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			phase_q     <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			phase_q <= phase_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (out_load) begin
			out_data_q <= {OUT_PAD_W'(0), CPOS_W'(lin_pos(row_q, col_q)),
				CCOL_W'(col_q), CROW_W'(row_q), entry_val};
		end
	end

	// Screen memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= ROW_LAST) && (col_q <= COL_LAST))
		else $error("cursor left the screen");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= CELL_LAST) && (base_q <= CELL_LAST))
		else $error("store write beyond the last cell");

	a_blank_on_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK) |-> (row_q == ROW_LAST) && (col_q == '0))
		else $error("row blanking without the cursor at the bottom row start");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> $past(state_q) == ST_IDLE)
		else $error("execute entered without a dispatch");

endmodule
